[hdl/dvrc_pkg.sv]
// ----------------------------------------------------------------------------
// dvrc_pkg
// Shared codes and types of the distance-vector route compute block.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrc_pkg;

    localparam logic [1:0] REQ_VEC_WRITE  = 2'd0;
    localparam logic [1:0] REQ_LINK_WRITE = 2'd1;
    localparam logic [1:0] REQ_COMPUTE    = 2'd2;

    localparam logic CFG_SELF_INDEX = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    // Commands from the sequencer to the relaxation unit.
    typedef struct packed {
        logic load_inf;
        logic load_self;
        logic relax;
    } relax_ctrl_t;

endpackage

`default_nettype wire

[hdl/dvrc_relax.sv]
// ----------------------------------------------------------------------------
// dvrc_relax
// Relaxation unit: holds the best cost, next hop and reachable flag of the
// destination under work and folds in one neighbor candidate per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrc_relax
    import dvrc_pkg::*;
#(
    parameter int IW         = 4,
    parameter int COST_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire relax_ctrl_t           ctrl,
    input  wire logic [IW-1:0]         self_hop,
    input  wire logic [IW-1:0]         cand_hop,
    input  wire logic [COST_WIDTH-1:0] link_cost,
    input  wire logic [COST_WIDTH-1:0] adv_cost,
    output logic [COST_WIDTH-1:0]      best_cost,
    output logic [IW-1:0]              best_hop,
    output logic                       reach
);

    localparam logic [COST_WIDTH-1:0] COST_INF = '1;

    logic [COST_WIDTH-1:0] best_cost_reg, best_cost_next;
    logic [IW-1:0]         best_hop_reg, best_hop_next;
    logic                  reach_reg, reach_next;
    logic [COST_WIDTH:0]   sum;
    logic                  take;

    assign sum = {1'b0, link_cost} + {1'b0, adv_cost};

    // A candidate counts only through a real neighbor with a finite sum.
    // Ties go to the later neighbor.
    assign take = (link_cost != '0) && (link_cost != COST_INF) &&
                  (adv_cost != COST_INF) && (sum < {1'b0, COST_INF}) &&
                  (sum <= {1'b0, best_cost_reg});

    always_comb
    begin
        best_cost_next = best_cost_reg;
        best_hop_next  = best_hop_reg;
        reach_next     = reach_reg;
        if (ctrl.load_inf)
        begin
            best_cost_next = COST_INF;
            best_hop_next  = '0;
            reach_next     = 1'b0;
        end
        else if (ctrl.load_self)
        begin
            best_cost_next = '0;
            best_hop_next  = self_hop;
            reach_next     = 1'b1;
        end
        else if (ctrl.relax && take)
        begin
            best_cost_next = sum[COST_WIDTH-1:0];
            best_hop_next  = cand_hop;
            reach_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_cost_reg <= COST_INF;
            best_hop_reg  <= '0;
            reach_reg     <= 1'b0;
        end
        else
        begin
            best_cost_reg <= best_cost_next;
            best_hop_reg  <= best_hop_next;
            reach_reg     <= reach_next;
        end
    end

    assign best_cost = best_cost_reg;
    assign best_hop  = best_hop_reg;
    assign reach     = reach_reg;

endmodule

`default_nettype wire

[hdl/distance_vector_route_compute.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_compute
// Bellman-Ford distance-vector route computation over an advertised-vector
// memory and a link-cost memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to their initial contents, one
// vector entry per cycle, over all 2**(2*ceil(log2(MAX_NODES))) vector entries
// (256 at the default size), and stalls its input during that pass. Vector and
// link-cost writes are then taken while idle and do not stall the input. A
// compute item walks the destinations in order: the own index goes from S_DEST
// straight to S_EMIT, and every other destination goes through S_DEST, S_SCAN
// and S_EMIT, where its n neighbors, n being the number of nodes in use, are
// read one per cycle through the single read port of each memory. Emission
// waits while the output is stalled, and the input stays stalled until the
// last route of the run is in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_compute
    import dvrc_pkg::*;
#(
    parameter int MAX_NODES  = 16,
    parameter int COST_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  row_node,
    input  wire logic [3:0]  col_node,
    input  wire logic [15:0] cost_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       dest_node,
    output logic [15:0]      route_cost,
    output logic [3:0]       next_hop,
    output logic             reachable,
    output logic             last_route
);

    localparam int IW        = $clog2(MAX_NODES);
    localparam int NW        = $clog2(MAX_NODES + 1);
    localparam int AW        = 2 * IW;
    localparam int VEC_DEPTH = 1 << AW;
    localparam int LNK_DEPTH = 1 << IW;
    localparam logic [COST_WIDTH-1:0] COST_INF = '1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DEST  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]    self_index_reg;
    logic [4:0]    node_count_reg;
    logic [NW-1:0] n_use;
    logic [IW-1:0] last_idx;

    logic [AW-1:0] clr_reg, clr_next;
    logic [IW-1:0] dest_reg, dest_next;
    logic [IW-1:0] nb_reg, nb_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_nb_reg;
    logic          rd_last_reg;

    logic [COST_WIDTH-1:0] vec_mem [0:VEC_DEPTH-1];
    logic [COST_WIDTH-1:0] lnk_mem [0:LNK_DEPTH-1];
    logic [COST_WIDTH-1:0] vec_rdata_reg;
    logic [COST_WIDTH-1:0] lnk_rdata_reg;

    logic                  vec_we;
    logic [AW-1:0]         vec_waddr;
    logic [COST_WIDTH-1:0] vec_wdata;
    logic                  lnk_we;
    logic [IW-1:0]         lnk_waddr;
    logic [COST_WIDTH-1:0] lnk_wdata;
    logic                  issue;
    logic [AW-1:0]         vec_raddr;

    logic                  in_fire;
    logic                  row_ok;
    logic                  col_ok;
    logic [COST_WIDTH-1:0] cost_in;
    logic                  is_self;
    logic                  is_last;
    logic                  emit_go;

    relax_ctrl_t           rctl;
    logic [COST_WIDTH-1:0] best_cost;
    logic [IW-1:0]         best_hop;
    logic                  reach;

    logic                  out_valid_reg;
    logic [3:0]            dest_node_reg;
    logic [15:0]           route_cost_reg;
    logic [3:0]            next_hop_reg;
    logic                  reachable_reg;
    logic                  last_route_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_index_reg <= 4'd0;
            node_count_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_INDEX: self_index_reg <= cfg_data[3:0];
                CFG_NODE_COUNT: node_count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (node_count_reg == 5'd0)
        begin
            n_use = NW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            n_use = NW'(MAX_NODES);
        end
        else
        begin
            n_use = NW'(node_count_reg);
        end
    end

    assign last_idx = IW'(n_use - NW'(1));

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign row_ok   = (32'(row_node) < MAX_NODES);
    assign col_ok   = (32'(col_node) < MAX_NODES);
    assign cost_in  = COST_WIDTH'(cost_value);
    assign is_self  = (32'(self_index_reg) == 32'(dest_reg));
    assign is_last  = (dest_reg == last_idx);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign issue    = (state_reg == S_SCAN) && !issue_done_reg;

    always_comb
    begin
        vec_we    = 1'b0;
        vec_waddr = {IW'(row_node), IW'(col_node)};
        vec_wdata = cost_in;
        lnk_we    = 1'b0;
        lnk_waddr = IW'(col_node);
        lnk_wdata = cost_in;
        if (state_reg == S_CLEAR)
        begin
            vec_we    = 1'b1;
            vec_waddr = clr_reg;
            vec_wdata = (clr_reg[AW-1:IW] == clr_reg[IW-1:0]) ? '0 : COST_INF;
            lnk_we    = 1'b1;
            lnk_waddr = clr_reg[IW-1:0];
            lnk_wdata = COST_INF;
        end
        else if (in_fire)
        begin
            vec_we = (req_type == REQ_VEC_WRITE) && row_ok && col_ok;
            lnk_we = (req_type == REQ_LINK_WRITE) && col_ok;
        end
    end

    assign vec_raddr = {nb_reg, dest_reg};

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        vec_rdata_reg <= vec_mem[vec_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        lnk_rdata_reg <= lnk_mem[nb_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        dest_next       = dest_reg;
        nb_next         = nb_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = issue;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire && (req_type == REQ_COMPUTE))
                begin
                    dest_next  = '0;
                    state_next = S_DEST;
                end
            end
            S_DEST:
            begin
                nb_next         = '0;
                issue_done_next = 1'b0;
                state_next      = is_self ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    if (nb_reg == last_idx)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        nb_next = nb_reg + IW'(1);
                    end
                end
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dest_next  = dest_reg + IW'(1);
                        state_next = S_DEST;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            dest_reg       <= '0;
            nb_reg         <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_nb_reg      <= '0;
            rd_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            dest_reg       <= dest_next;
            nb_reg         <= nb_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            rd_nb_reg      <= nb_reg;
            rd_last_reg    <= (nb_reg == last_idx);
        end
    end

    assign rctl.load_inf  = (state_reg == S_DEST) && !is_self;
    assign rctl.load_self = (state_reg == S_DEST) && is_self;
    assign rctl.relax     = rd_vld_reg;

    dvrc_relax #(
        .IW         (IW),
        .COST_WIDTH (COST_WIDTH)
    ) u_relax (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rctl),
        .self_hop  (IW'(self_index_reg)),
        .cand_hop  (rd_nb_reg),
        .link_cost (lnk_rdata_reg),
        .adv_cost  (vec_rdata_reg),
        .best_cost (best_cost),
        .best_hop  (best_hop),
        .reach     (reach)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            dest_node_reg  <= 4'(dest_reg);
            route_cost_reg <= 16'(best_cost);
            next_hop_reg   <= 4'(best_hop);
            reachable_reg  <= reach;
            last_route_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_node  = dest_node_reg;
    assign route_cost = route_cost_reg;
    assign next_hop   = next_hop_reg;
    assign reachable  = reachable_reg;
    assign last_route = last_route_reg;

    // Read data comes back only while a destination is being scanned.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN))
        else $error("neighbor read data returned outside a scan");

    // The final route of a run releases the input.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && is_last) |=> (state_reg == S_IDLE))
        else $error("compute run did not end after its last route");

    // An unreachable route reports hop zero.
    a_unreach_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !reachable_reg) |-> (next_hop_reg == 4'd0))
        else $error("unreachable route with a nonzero next hop");

    // Memories are written by the clearing pass or by an accepted item only.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_we || lnk_we) |-> ((state_reg == S_CLEAR) || in_fire))
        else $error("table write without a clearing pass or an item");

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance-vector route compute block.
// Vector and link-cost writes build the routing tables, compute items are
// checked route by route against a behavioral Bellman-Ford predictor, and both
// sides of the handshake idle at random across several node settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import dvrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [15:0] COST_INF      = 16'hFFFF;
    localparam int          TABLE_NODES   = 16;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          DRAIN_CYCLES  = 400;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 29;

    typedef struct packed {
        logic [3:0]  dest;
        logic [15:0] cost;
        logic [3:0]  hop;
        logic        reach;
        logic        last;
    } route_t;

    class route_scoreboard;
        logic [15:0] adv_cost [TABLE_NODES][TABLE_NODES];
        logic [15:0] link_cost [TABLE_NODES];
        logic [3:0]  self_idx;
        logic [4:0]  node_cnt;
        route_t      expected_routes [$];
        int          errors;

        function new();
            for (int i = 0; i < TABLE_NODES; i++)
            begin
                for (int j = 0; j < TABLE_NODES; j++)
                    adv_cost[i][j] = (i == j) ? 16'd0 : COST_INF;
                link_cost[i] = COST_INF;
            end
            self_idx = 4'd0;
            node_cnt = 5'd16;
            errors   = 0;
        endfunction

        function int active_nodes();
            if (node_cnt == 5'd0)
                return 1;
            if (node_cnt > TABLE_NODES)
                return TABLE_NODES;
            return int'(node_cnt);
        endfunction

        function void set_register(logic index, logic [4:0] data);
            if (index == CFG_SELF_INDEX)
                self_idx = data[3:0];
            else
                node_cnt = data;
        endfunction

        function void note_item(logic [1:0] req, logic [3:0] row, logic [3:0] col,
                                logic [15:0] cost);
            int          n;
            route_t      r;
            logic [16:0] sum;
            if (req == REQ_VEC_WRITE)
                adv_cost[row][col] = cost;
            else if (req == REQ_LINK_WRITE)
                link_cost[col] = cost;
            else if (req == REQ_COMPUTE)
            begin
                n = active_nodes();
                for (int d = 0; d < n; d++)
                begin
                    r.dest = 4'(d);
                    if (4'(d) == self_idx)
                    begin
                        r.cost  = 16'd0;
                        r.hop   = self_idx;
                        r.reach = 1'b1;
                    end
                    else
                    begin
                        r.cost  = COST_INF;
                        r.hop   = 4'd0;
                        r.reach = 1'b0;
                        for (int k = 0; k < n; k++)
                        begin
                            if (link_cost[k] == 16'd0 || link_cost[k] == COST_INF ||
                                adv_cost[k][d] == COST_INF)
                                continue;
                            sum = {1'b0, link_cost[k]} + {1'b0, adv_cost[k][d]};
                            if (sum >= {1'b0, COST_INF})
                                continue;
                            if (sum[15:0] <= r.cost)
                            begin
                                r.cost  = sum[15:0];
                                r.hop   = 4'(k);
                                r.reach = 1'b1;
                            end
                        end
                    end
                    r.last = (d == n - 1);
                    expected_routes.push_back(r);
                end
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_route(route_t got);
            route_t want;
            if (expected_routes.size() == 0)
            begin
                $display("%0t ns: unexpected route for dest %0d, expected none, actual cost %0d",
                         $time, got.dest, got.cost);
                errors++;
                return;
            end
            want = expected_routes.pop_front();
            compare_field("dest_node", want.dest, got.dest);
            compare_field("route_cost", want.cost, got.cost);
            compare_field("next_hop", want.hop, got.hop);
            compare_field("reachable", want.reach, got.reach);
            compare_field("last_route", want.last, got.last);
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [4:0]  cfg_data   = 5'd0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type   = 2'd0;
    logic [3:0]  row_node   = 4'd0;
    logic [3:0]  col_node   = 4'd0;
    logic [15:0] cost_value = 16'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [3:0]  dest_node;
    logic [15:0] route_cost;
    logic [3:0]  next_hop;
    logic        reachable;
    logic        last_route;

    bit              quiet = 1'b0;
    route_scoreboard routes = new();

    logic [3:0] phase_self  [PHASES] = '{4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd9, 4'd14, 4'd0};
    logic [4:0] phase_count [PHASES] = '{5'd16, 5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2};

    distance_vector_route_compute u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .row_node   (row_node),
        .col_node   (col_node),
        .cost_value (cost_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dest_node  (dest_node),
        .route_cost (route_cost),
        .next_hop   (next_hop),
        .reachable  (reachable),
        .last_route (last_route)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            routes.check_route('{dest_node, route_cost, next_hop, reachable, last_route});
        out_stall <= !quiet && ($urandom_range(0, 99) < 19);
    end

    task automatic send_item(input logic [1:0] req, input logic [3:0] row,
                             input logic [3:0] col, input logic [15:0] cost);
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        row_node   <= row;
        col_node   <= col;
        cost_value <= cost;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        routes.note_item(req, row, col, cost);
    endtask

    task automatic wait_for_routes();
        in_valid <= 1'b0;
        while (routes.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [3:0] self_value, input logic [4:0] count_value);
        logic [4:0] self_word;
        self_word = {1'($urandom_range(0, 1)), self_value};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SELF_INDEX;
        cfg_data  <= self_word;
        @(posedge clk);
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= count_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        routes.set_register(CFG_SELF_INDEX, self_word);
        routes.set_register(CFG_NODE_COUNT, count_value);
    endtask

    function automatic logic [15:0] random_cost();
        case ($urandom_range(0, 5))
            0:       return COST_INF;
            1:       return 16'd0;
            2, 3:    return 16'($urandom_range(1, 8));
            4:       return 16'($urandom_range(16'hFF00, 16'hFFFE));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int span);
        int          pick;
        logic [1:0]  req;
        logic [3:0]  row;
        logic [3:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            req = REQ_VEC_WRITE;
        else if (pick < 82)
            req = REQ_LINK_WRITE;
        else if (pick < 93)
            req = REQ_COMPUTE;
        else
            req = REQ_UNUSED;
        row = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                            4'($urandom_range(0, span - 1));
        col = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                            4'($urandom_range(0, span - 1));
        send_item(req, row, col, random_cost());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);

        write_settings(phase_self[0], phase_count[0]);
        send_item(REQ_LINK_WRITE, 4'd0, 4'd1, 16'd10);
        send_item(REQ_LINK_WRITE, 4'd0, 4'd2, 16'd4);
        send_item(REQ_LINK_WRITE, 4'd15, 4'd0, 16'd0);
        send_item(REQ_LINK_WRITE, 4'd0, 4'd15, COST_INF);
        send_item(REQ_LINK_WRITE, 4'd0, 4'd3, 16'd7);
        send_item(REQ_LINK_WRITE, 4'd0, 4'd4, 16'hFFFE);
        send_item(REQ_VEC_WRITE, 4'd1, 4'd5, 16'd5);
        send_item(REQ_VEC_WRITE, 4'd2, 4'd5, 16'd11);
        send_item(REQ_VEC_WRITE, 4'd1, 4'd6, 16'hFFFE);
        send_item(REQ_VEC_WRITE, 4'd2, 4'd6, COST_INF);
        send_item(REQ_VEC_WRITE, 4'd0, 4'd7, 16'd1);
        send_item(REQ_VEC_WRITE, 4'd15, 4'd15, 16'd0);
        send_item(REQ_VEC_WRITE, 4'd3, 4'd8, 16'd2);
        send_item(REQ_VEC_WRITE, 4'd4, 4'd9, 16'd1);
        send_item(REQ_VEC_WRITE, 4'd4, 4'd10, 16'd0);
        send_item(REQ_VEC_WRITE, 4'd2, 4'd3, 16'd1);
        send_item(REQ_UNUSED, 4'd15, 4'd15, COST_INF);
        send_item(REQ_COMPUTE, 4'd0, 4'd0, 16'd0);
        send_item(REQ_VEC_WRITE, 4'd15, 4'd0, 16'hAAAA);
        send_item(REQ_COMPUTE, 4'd15, 4'd15, 16'h5555);

        for (int p = 1; p < PHASES; p++)
        begin
            wait_for_routes();
            write_settings(phase_self[p], phase_count[p]);
            quiet = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random(routes.active_nodes());
                if ($urandom_range(0, 24) == 0)
                    wait_for_routes();
            end
            send_item(REQ_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom));
        end
        quiet = 1'b0;

        wait_for_routes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (routes.errors == 0 && routes.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
